FILE: rtl/lsms_pkg.sv
package lsms_pkg;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	localparam int unsigned FRAME_LENGTH_DEF = 70224;

	localparam int unsigned CNT_W = 18;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CNT_W-1:0] OAM_CYCLES    = 18'd80;
	localparam logic [CNT_W-1:0] XFER_CYCLES   = 18'd170;
	localparam logic [CNT_W-1:0] HBLANK_CYCLES = 18'd206;
	localparam logic [CNT_W-1:0] LINE_CYCLES   = 18'd456;

	localparam logic [7:0] LINE_LAST      = 8'd153;
	localparam logic [7:0] LINE_VIS_LAST  = 8'd143;
	localparam logic [7:0] LINE_VBL_FIRST = 8'd144;
	localparam logic [7:0] LINE_RESET     = 8'h91;
	localparam logic [7:0] LINE_PRE_WRAP  = 8'hFF;

	localparam int unsigned EN_COINC = 3;

	typedef struct packed {
		logic [CNT_W-1:0] dot_count;
		logic [CNT_W-1:0] dot_target;
		logic [7:0]       line_count;
		mode_t            current_mode;
		mode_t            pending_mode;
		logic             match_flag;
	} state_t;

	typedef struct packed {
		logic [7:0] line;
		mode_t      mode;
		logic       coincidence;
		logic       vblank_irq;
		logic       stat_irq;
		logic       draw_line;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

FILE: rtl/lsms_step.sv
module lsms_step #(
	parameter int unsigned FRAME_LENGTH = lsms_pkg::FRAME_LENGTH_DEF
) (
	input  lsms_pkg::state_t  cur,
	input  logic [7:0]        cycles,
	input  logic              display_on,
	input  logic [7:0]        compare_line,
	input  logic [3:0]        stat_enables,
	output lsms_pkg::state_t  nxt,
	output lsms_pkg::result_t res
);

	localparam int unsigned W = lsms_pkg::CNT_W;
	localparam logic [W:0] FL1 = (W+1)'(FRAME_LENGTH);
	localparam logic [W:0] FL2 = (W+1)'(2 * FRAME_LENGTH);
	localparam logic [W:0] FL3 = (W+1)'(3 * FRAME_LENGTH);

	logic [W-1:0]    dc;
	logic [W:0]      dc_x;
	logic [W:0]      dc_mod_x;
	logic [W-1:0]    dc_mod;
	logic [W-1:0]    tgt;
	logic [7:0]      ln;
	logic [7:0]      ln_inc;
	lsms_pkg::mode_t pm;
	logic            hit;
	logic            vbl;
	logic            stat;
	logic            draw;

	always_comb begin
		dc   = lsms_pkg::sat_add(cur.dot_count, W'(cycles));
		dc_x = {1'b0, dc};
		priority if (dc_x >= FL3) begin
			dc_mod_x = dc_x - FL3;
		end else if (dc_x >= FL2) begin
			dc_mod_x = dc_x - FL2;
		end else if (dc_x >= FL1) begin
			dc_mod_x = dc_x - FL1;
		end else begin
			dc_mod_x = dc_x;
		end
		dc_mod = dc_mod_x[W-1:0];

		nxt    = cur;
		vbl    = 1'b0;
		stat   = 1'b0;
		draw   = 1'b0;
		pm     = cur.pending_mode;
		ln     = cur.line_count;
		tgt    = cur.dot_target;
		ln_inc = ln + 8'd1;
		hit    = 1'b0;
		nxt.dot_count = dc;

		if (display_on) begin
			if (dc >= cur.dot_target) begin
				if (cur.line_count == lsms_pkg::LINE_LAST) begin
					pm  = lsms_pkg::MODE_OAM;
					ln  = lsms_pkg::LINE_PRE_WRAP;
					tgt = W'(FRAME_LENGTH);
					nxt.dot_count = dc_mod;
				end
				ln_inc = ln + 8'd1;
				hit    = (compare_line == ln_inc);
				if (cur.current_mode != pm && pm != lsms_pkg::MODE_XFER && stat_enables[pm])
					stat = 1'b1;
				nxt.current_mode = pm;
				nxt.line_count   = ln;
				unique case (pm)
					lsms_pkg::MODE_OAM: begin
						nxt.dot_target   = lsms_pkg::sat_add(tgt, lsms_pkg::OAM_CYCLES);
						nxt.pending_mode = lsms_pkg::MODE_XFER;
						nxt.line_count   = ln_inc;
						nxt.match_flag   = hit;
						stat = stat | (hit & stat_enables[lsms_pkg::EN_COINC]);
					end
					lsms_pkg::MODE_XFER: begin
						nxt.dot_target   = lsms_pkg::sat_add(tgt, lsms_pkg::XFER_CYCLES);
						nxt.pending_mode = lsms_pkg::MODE_HBLANK;
					end
					lsms_pkg::MODE_HBLANK: begin
						nxt.dot_target = lsms_pkg::sat_add(tgt, lsms_pkg::HBLANK_CYCLES);
						if (ln <= lsms_pkg::LINE_VIS_LAST) begin
							nxt.pending_mode = lsms_pkg::MODE_OAM;
							draw = 1'b1;
						end else begin
							nxt.pending_mode = lsms_pkg::MODE_VBLANK;
						end
					end
					lsms_pkg::MODE_VBLANK: begin
						nxt.dot_target   = lsms_pkg::sat_add(tgt, lsms_pkg::LINE_CYCLES);
						nxt.pending_mode = lsms_pkg::MODE_VBLANK;
						vbl = (ln == lsms_pkg::LINE_VBL_FIRST);
						nxt.line_count   = ln_inc;
						nxt.match_flag   = hit;
						stat = stat | (hit & stat_enables[lsms_pkg::EN_COINC]);
					end
					default: begin
						nxt.pending_mode = lsms_pkg::MODE_VBLANK;
					end
				endcase
			end
		end else begin
			nxt.dot_count = dc_mod;
		end

		res.line        = nxt.line_count;
		res.mode        = nxt.current_mode;
		res.coincidence = nxt.match_flag;
		res.vblank_irq  = vbl;
		res.stat_irq    = stat;
		res.draw_line   = draw;
	end

endmodule

FILE: rtl/lcd_scanline_mode_sequencer_core.sv
// LCD scanline mode sequencer.
// Request channel: req_valid/req_ready carry one tick (cycles, display_on,
// compare_line, stat_enables). A request is taken at a clock edge with both high.
// Result channel: res_valid/res_ready carry line, mode, coincidence, vblank_irq,
// stat_irq and draw_line, one result for every request, in order.
// A taken request is held in the request stage; its result is then registered
// in the result register. Throughput: one request per cycle while the receiver
// takes results; the dot counter, line counter and mode registers update together
// from the held request, so ticks stream back to back with no gaps.
// A stalled receiver holds the result register; the held request stage then
// stays full and req_ready falls in the same cycle, so nothing is lost.
// Reset (arst_n low): both stages empty, dot counter and target zero, line 145,
// mode hblank, next mode oam scan, coincidence flag clear.
// While display_on is low only the dot counter moves, wrapping at FRAME_LENGTH.
module lcd_scanline_mode_sequencer_core #(
	parameter int unsigned FRAME_LENGTH = lsms_pkg::FRAME_LENGTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [7:0]      cycles,
	input  logic            display_on,
	input  logic [7:0]      compare_line,
	input  logic [3:0]      stat_enables,
	output logic            res_valid,
	input  logic            res_ready,
	output logic [7:0]      line,
	output logic [1:0]      mode,
	output logic            coincidence,
	output logic            vblank_irq,
	output logic            stat_irq,
	output logic            draw_line
);

	logic              valid_s1;
	logic [7:0]        cycles_s1;
	logic              display_on_s1;
	logic [7:0]        compare_line_s1;
	logic [3:0]        stat_enables_s1;
	logic              adv_s1;
	lsms_pkg::state_t  state_q;
	lsms_pkg::state_t  state_nxt;
	lsms_pkg::result_t res_nxt;
	lsms_pkg::result_t res_q;
	logic              res_valid_q;

	assign adv_s1    = valid_s1 && (!res_valid_q || res_ready);
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cycles_s1       <= cycles;
			display_on_s1   <= display_on;
			compare_line_s1 <= compare_line;
			stat_enables_s1 <= stat_enables;
		end
	end

	lsms_step #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) u_step (
		.cur         (state_q),
		.cycles      (cycles_s1),
		.display_on  (display_on_s1),
		.compare_line(compare_line_s1),
		.stat_enables(stat_enables_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.dot_count    <= '0;
			state_q.dot_target   <= '0;
			state_q.line_count   <= lsms_pkg::LINE_RESET;
			state_q.current_mode <= lsms_pkg::MODE_HBLANK;
			state_q.pending_mode <= lsms_pkg::MODE_OAM;
			state_q.match_flag   <= 1'b0;
			res_valid_q          <= 1'b0;
		end else begin
			if (adv_s1)
				state_q <= state_nxt;
			if (adv_s1)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_q <= res_nxt;
	end

	assign res_valid   = res_valid_q;
	assign line        = res_q.line;
	assign mode        = res_q.mode;
	assign coincidence = res_q.coincidence;
	assign vblank_irq  = res_q.vblank_irq;
	assign stat_irq    = res_q.stat_irq;
	assign draw_line   = res_q.draw_line;

`ifndef SYNTHESIS
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line_count <= lsms_pkg::LINE_LAST)
		else $error("line counter beyond last frame line");

	a_vbl_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && vblank_irq |-> mode == lsms_pkg::MODE_VBLANK)
		else $error("vblank interrupt outside vblank");

	a_draw_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && draw_line |->
			mode == lsms_pkg::MODE_HBLANK && line <= lsms_pkg::LINE_VIS_LAST)
		else $error("draw request outside visible hblank");

	a_xfer_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.current_mode == lsms_pkg::MODE_XFER |->
			state_q.pending_mode == lsms_pkg::MODE_HBLANK)
		else $error("transfer not followed by hblank");
`endif

endmodule

FILE: sim/lcd_scanline_mode_sequencer_core_tb.sv
`timescale 1ns / 100ps

module lcd_scanline_mode_sequencer_core_tb;

	import lsms_pkg::*;

	class lcd_timing_board;
		logic [CNT_W-1:0] dots;
		logic [CNT_W-1:0] target;
		logic [7:0]       line_no;
		mode_t            cur;
		mode_t            nxt;
		logic             match;
		result_t          status_due[$];
		int               errors;
		int               vblanks;

		function new();
			dots = '0;
			target = '0;
			line_no = LINE_RESET;
			cur = MODE_HBLANK;
			nxt = MODE_OAM;
			match = 1'b0;
			errors = 0;
			vblanks = 0;
		endfunction

		function logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] a, input int unsigned b);
			int unsigned sum;
			sum = a + b;
			return (sum > CNT_MAX) ? CNT_MAX : CNT_W'(sum);
		endfunction

		function logic compare_line_no(input logic [7:0] cmp, input logic [3:0] sen);
			match = (cmp == line_no);
			return match & sen[EN_COINC];
		endfunction

		function void note_tick(input logic [7:0] cyc, input logic en, input logic [7:0] cmp,
				input logic [3:0] sen);
			result_t r;
			logic stat, vbl, draw;
			stat = 1'b0;
			vbl = 1'b0;
			draw = 1'b0;
			dots = add_sat(dots, cyc);
			if (en) begin
				if (dots >= target) begin
					if (line_no == LINE_LAST) begin
						nxt = MODE_OAM;
						line_no = LINE_PRE_WRAP;
						dots = CNT_W'(dots % FRAME_LENGTH_DEF);
						target = CNT_W'(FRAME_LENGTH_DEF);
					end
					if (cur != nxt) begin
						cur = nxt;
						if (cur != MODE_XFER && sen[int'(cur)])
							stat = 1'b1;
					end
					case (cur)
						MODE_OAM: begin
							target = add_sat(target, OAM_CYCLES);
							nxt = MODE_XFER;
							line_no = line_no + 8'd1;
							stat |= compare_line_no(cmp, sen);
						end
						MODE_XFER: begin
							target = add_sat(target, XFER_CYCLES);
							nxt = MODE_HBLANK;
						end
						MODE_HBLANK: begin
							target = add_sat(target, HBLANK_CYCLES);
							if (line_no <= LINE_VIS_LAST) begin
								nxt = MODE_OAM;
								draw = 1'b1;
							end else begin
								nxt = MODE_VBLANK;
							end
						end
						default: begin
							target = add_sat(target, LINE_CYCLES);
							nxt = MODE_VBLANK;
							vbl = (line_no == LINE_VBL_FIRST);
							line_no = line_no + 8'd1;
							stat |= compare_line_no(cmp, sen);
						end
					endcase
				end
			end else if (dots >= FRAME_LENGTH_DEF) begin
				dots = CNT_W'(dots % FRAME_LENGTH_DEF);
			end
			r.line = line_no;
			r.mode = cur;
			r.coincidence = match;
			r.vblank_irq = vbl;
			r.stat_irq = stat;
			r.draw_line = draw;
			if (vbl)
				vblanks++;
			status_due.push_back(r);
		endfunction

		task report_mismatch(input string msg);
			$display("%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_status(input result_t got);
			result_t want;
			if (status_due.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = status_due.pop_front();
				if (got.line !== want.line)
					report_mismatch($sformatf("line got %0d want %0d", got.line, want.line));
				if (got.mode !== want.mode)
					report_mismatch($sformatf("mode got %0d want %0d", got.mode, want.mode));
				if (got.coincidence !== want.coincidence)
					report_mismatch($sformatf("coincidence got %0b want %0b",
						got.coincidence, want.coincidence));
				if (got.vblank_irq !== want.vblank_irq)
					report_mismatch($sformatf("vblank_irq got %0b want %0b",
						got.vblank_irq, want.vblank_irq));
				if (got.stat_irq !== want.stat_irq)
					report_mismatch($sformatf("stat_irq got %0b want %0b",
						got.stat_irq, want.stat_irq));
				if (got.draw_line !== want.draw_line)
					report_mismatch($sformatf("draw_line got %0b want %0b",
						got.draw_line, want.draw_line));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	logic [7:0] cycles;
	logic       display_on;
	logic [7:0] compare_line;
	logic [3:0] stat_enables;
	logic       res_valid;
	logic       res_ready;
	logic [7:0] line;
	logic [1:0] mode;
	logic       coincidence;
	logic       vblank_irq;
	logic       stat_irq;
	logic       draw_line;
	bit         quiet = 1'b0;

	lcd_timing_board sb = new();

	lcd_scanline_mode_sequencer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.cycles       (cycles),
		.display_on   (display_on),
		.compare_line (compare_line),
		.stat_enables (stat_enables),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.line         (line),
		.mode         (mode),
		.coincidence  (coincidence),
		.vblank_irq   (vblank_irq),
		.stat_irq     (stat_irq),
		.draw_line    (draw_line)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_tick(input logic [7:0] cyc, input logic en, input logic [7:0] cmp,
			input logic [3:0] sen);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		cycles <= cyc;
		display_on <= en;
		compare_line <= cmp;
		stat_enables <= sen;
		do @(posedge clk); while (!req_ready);
		sb.note_tick(cyc, en, cmp, sen);
	endtask

	task automatic drain_status();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.status_due.size() != 0) @(posedge clk);
	endtask

	task automatic random_tick(input bit noisy);
		logic [7:0] cyc, cmp;
		logic       en;
		int         pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			cyc = 8'($urandom_range(192, 255));
		else if (pick < 90)
			cyc = 8'($urandom_range(0, 255));
		else
			cyc = $urandom_range(0, 1) ? 8'd255 : 8'd0;
		en = 1'b1;
		if (noisy)
			en = 1'($urandom_range(0, 1));
		else if ($urandom_range(0, 9) == 0 && sb.dots + cyc < FRAME_LENGTH_DEF)
			en = 1'b0;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			cmp = sb.line_no + 8'd1;
		else if (pick < 6)
			cmp = sb.line_no;
		else if (pick < 8)
			cmp = 8'($urandom_range(0, LINE_LAST));
		else
			cmp = 8'($urandom_range(0, 255));
		send_tick(cyc, en, cmp, 4'($urandom_range(0, 15)));
	endtask

	initial begin
		int burst;
		res_ready = 1'b0;
		forever begin
			burst = $urandom_range(1, 7);
			@(negedge clk);
			if (arst_n && (quiet || $urandom_range(0, 2) != 0))
				res_ready <= 1'b1;
			else
				res_ready <= 1'b0;
			repeat (burst - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_status('{line, mode_t'(mode), coincidence, vblank_irq, stat_irq, draw_line});
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		cycles = '0;
		display_on = 1'b0;
		compare_line = '0;
		stat_enables = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_tick(8'd0, 1'b0, 8'd0, 4'h0);
		send_tick(8'd255, 1'b0, 8'd255, 4'hF);
		send_tick(8'd0, 1'b1, 8'd146, 4'hF);
		send_tick(8'd0, 1'b1, 8'd0, 4'h0);
		send_tick(8'd0, 1'b1, 8'd0, 4'h1);
		send_tick(8'd255, 1'b1, 8'd147, 4'h2);
		send_tick(8'd255, 1'b1, 8'd148, 4'hF);
		send_tick(8'd255, 1'b1, 8'd148, 4'hA);
		// advance through the last vblank lines into the frame wrap
		repeat (13) send_tick(8'd255, 1'b1, 8'd0, 4'hC);
		send_tick(8'd255, 1'b1, 8'd255, 4'h0);
		drain_status();

		n = 0;
		while ((n < 400 || sb.vblanks == 0) && n < 3000) begin
			random_tick(1'b0);
			n++;
			if (n == 200)
				drain_status();
		end

		quiet = 1'b1;
		repeat (100) random_tick(1'b1);

		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.status_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
